FILE: rtl/core/ragr_pkg.sv
// Package: widths, operation codes, sequencer states and divider control/status types for the fraction reducer.
`default_nettype none
package ragr_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 33;
    localparam int PROD_W = 2 * OPERAND_WIDTH + 1;
    localparam int MAG_W  = 2 * OPERAND_WIDTH + 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_QN_START,
        ST_QN_WAIT,
        ST_QD_START,
        ST_QD_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

FILE: rtl/core/ragr_div.sv
// Shared restoring divider: one quotient bit a cycle on unsigned magnitudes.
`default_nettype none
module ragr_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ragr_pkg::t_div_ctrl       i_ctrl,
    input  wire logic [ragr_pkg::MAG_W-1:0] i_dividend,
    input  wire logic [ragr_pkg::MAG_W-1:0] i_divisor,
    output ragr_pkg::t_div_stat            o_stat,
    output logic [ragr_pkg::MAG_W-1:0]     o_quot,
    output logic [ragr_pkg::MAG_W-1:0]     o_rem
);
    import ragr_pkg::*;

    logic [MAG_W-1:0] r_q, n_q, r_r, n_r, r_d, n_d;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [MAG_W:0]   w_sh, w_diff;

    // one shift-subtract step
    always_comb begin
        w_sh   = {r_r, r_q[MAG_W-1]};
        w_diff = w_sh - {1'b0, r_d};
        n_q = r_q; n_r = r_r; n_d = r_d; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_ctrl.start) begin
            n_q = i_dividend; n_r = '0; n_d = i_divisor;
            n_cnt = CNT_W'(MAG_W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[MAG_W]) begin
                n_r = w_diff[MAG_W-1:0];
                n_q = {r_q[MAG_W-2:0], 1'b1};
            end else begin
                n_r = w_sh[MAG_W-1:0];
                n_q = {r_q[MAG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> r_busy) else $error("done without busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("count ran out while busy");
endmodule
`default_nettype wire

FILE: rtl/core/rational_arith_gcd_reduce_top.sv
// Top level: fraction arithmetic with gcd reduction under a small sequencer.
`default_nettype none
// One transfer in gives one transfer out. An item forms its cross products in states
// ST_MUL0, ST_MUL1 and ST_MUL2 on one shared multiplier, then runs Euclid's remainder
// loop and two final divisions on one shared restoring divider. From one accepted
// transfer the block is not ready until the item is done and the previous result no
// longer waits on i_stall. A zero numerator or a zero denominator skips reduction.
// A zero denominator raises o_den_zero with o_res_den at zero.
module rational_arith_gcd_reduce_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_func,
    input  wire logic signed [ragr_pkg::IN_W-1:0] i_a_num,
    input  wire logic signed [ragr_pkg::IN_W-1:0] i_a_den,
    input  wire logic signed [ragr_pkg::IN_W-1:0] i_b_num,
    input  wire logic signed [ragr_pkg::IN_W-1:0] i_b_den,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [ragr_pkg::OUT_W-1:0] o_res_num,
    output logic signed [ragr_pkg::OUT_W-1:0] o_res_den,
    output logic                             o_den_zero
);
    import ragr_pkg::*;

    localparam int OW = OPERAND_WIDTH;

    t_state r_state, n_state;
    t_func  r_func;
    logic signed [OW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_num, r_den;
    logic [MAG_W-1:0] r_x, r_y, r_mn, r_md, r_g;
    logic r_neg;
    logic r_ovalid;
    logic signed [OUT_W-1:0] r_onum, r_oden;
    logic r_ozero;

    logic signed [OW-1:0] w_ma, w_mb;
    logic signed [2*OW-1:0] w_prod;
    t_div_ctrl w_dctrl;
    t_div_stat w_dstat;
    logic [MAG_W-1:0] w_dvd, w_dvs, w_quot, w_rem;
    logic w_acc, w_out_take;

    assign w_acc      = i_valid && !o_stall;
    assign w_out_take = r_ovalid && !i_stall;
    assign o_stall    = (r_state != ST_IDLE);

    // multiplier operand select
    always_comb begin
        w_ma = r_an; w_mb = r_bd;
        unique case (r_state)
            ST_MUL1: begin w_ma = r_bn; w_mb = (r_func == FUNC_MUL) ? r_bn : r_ad; end
            ST_MUL2: begin w_ma = r_ad; w_mb = (r_func == FUNC_DIV) ? r_bn : r_bd; end
            default: begin w_ma = r_an; w_mb = (r_func == FUNC_MUL) ? r_bn : r_bd; end
        endcase
        w_prod = w_ma * w_mb;
    end

    // divider operand select
    always_comb begin
        w_dctrl.start = (r_state == ST_GCD_START) || (r_state == ST_QN_START) ||
                        (r_state == ST_QD_START);
        w_dvs = (r_state == ST_GCD_START) ? r_y : r_g;
        w_dvd = (r_state == ST_GCD_START) ? r_x :
                (r_state == ST_QN_START) ? r_mn : r_md;
    end

    ragr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_dctrl),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_stat(w_dstat), .o_quot(w_quot), .o_rem(w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_acc) n_state = ST_MUL0;
            ST_MUL0:      n_state = ST_MUL1;
            ST_MUL1:      n_state = ST_MUL2;
            ST_MUL2:      n_state = ST_CHECK;
            ST_CHECK:     n_state = (r_den == '0) ? ST_DONE :
                                    (r_num == '0) ? ST_DONE : ST_GCD_START;
            ST_GCD_START: n_state = ST_GCD_WAIT;
            ST_GCD_WAIT:  if (w_dstat.done)
                              n_state = (w_rem == '0) ? ST_QN_START : ST_GCD_START;
            ST_QN_START:  n_state = ST_QN_WAIT;
            ST_QN_WAIT:   if (w_dstat.done) n_state = ST_QD_START;
            ST_QD_START:  n_state = ST_QD_WAIT;
            ST_QD_WAIT:   if (w_dstat.done) n_state = ST_DONE;
            ST_DONE:      if (!r_ovalid || w_out_take) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (w_acc) begin
                r_func <= t_func'(i_func);
                r_an <= i_a_num[OW-1:0]; r_ad <= i_a_den[OW-1:0];
                r_bn <= i_b_num[OW-1:0]; r_bd <= i_b_den[OW-1:0];
            end
            ST_MUL0: r_p0 <= PROD_W'(w_prod);
            ST_MUL1: r_p1 <= PROD_W'(w_prod);
            ST_MUL2: begin
                r_den <= PROD_W'(w_prod);
                unique case (r_func)
                    FUNC_ADD: r_num <= r_p0 + r_p1;
                    FUNC_SUB: r_num <= r_p0 - r_p1;
                    default:  r_num <= r_p0;
                endcase
            end
            ST_CHECK: begin
                r_neg <= (r_num[PROD_W-1] != r_den[PROD_W-1]);
                r_mn  <= r_num[PROD_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
                r_md  <= r_den[PROD_W-1] ? MAG_W'(-r_den) : MAG_W'(r_den);
                r_x   <= r_num[PROD_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
                r_y   <= r_den[PROD_W-1] ? MAG_W'(-r_den) : MAG_W'(r_den);
            end
            ST_GCD_WAIT: if (w_dstat.done) begin
                r_x <= r_y; r_y <= w_rem; r_g <= r_y;
            end
            ST_QN_WAIT: if (w_dstat.done) r_mn <= w_quot;
            ST_QD_WAIT: if (w_dstat.done) r_md <= w_quot;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && (!r_ovalid || w_out_take)) r_ovalid <= 1'b1;
            else if (w_out_take) r_ovalid <= 1'b0;
        end
        if (r_state == ST_DONE && (!r_ovalid || w_out_take)) begin
            if (r_den == '0) begin
                r_onum <= OUT_W'(r_num); r_oden <= '0; r_ozero <= 1'b1;
            end else if (r_num == '0) begin
                r_onum <= '0; r_oden <= OUT_W'(1); r_ozero <= 1'b0;
            end else begin
                r_onum <= r_neg ? OUT_W'(-r_mn) : OUT_W'(r_mn);
                r_oden <= OUT_W'(r_md); r_ozero <= 1'b0;
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_res_num  = r_onum;
    assign o_res_den  = r_oden;
    assign o_den_zero = r_ozero;

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accepted while busy");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD_START) |-> (r_y != '0)) else $error("zero divisor in loop");
    a_qn_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QN_START) |-> (r_g != '0)) else $error("zero gcd");
endmodule
`default_nettype wire
